FILE: sv/aes_pkg.sv
// AES-128 package: S-box tables, GF(2^8) helpers and shared types.
// No dependencies; used by every module of the cipher unit.
`default_nettype none
package aes_pkg;

	localparam int NUM_ROUNDS = 10;
	localparam int KEY_WORDS  = 4 * (NUM_ROUNDS + 1);
	localparam int KIDX_W     = $clog2(KEY_WORDS);
	localparam int ROUND_W    = $clog2(NUM_ROUNDS + 1);

	localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
	localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] SBOX_INV [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// Column mix: m0..m3 for the forward matrix {02,03,01,01}.
	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
			xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
	endfunction

	// Inverse mix as a pre-step then forward mix: {0e,0b,0d,09} = fwd * {05,00,04,00}.
	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, u, v;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		u = xt(xt(a0 ^ a2));
		v = xt(xt(a1 ^ a3));
		return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
	endfunction

	typedef struct packed {
		logic             first;
		logic             last;
		logic             dec;
	} rnd_ctl_t;

endpackage
`default_nettype wire

FILE: sv/aes128_block_cipher_unit.sv
// AES-128 block cipher unit top level: sequencer, key expansion and round datapath.
// Depends on aes_pkg, aes_key_mem and aes_round.
`default_nettype none
// One block at a time, encrypt or decrypt, ECB. Pulse start while busy is low with
// func, block_high and block_low; busy rises at once. The result appears on
// result_high/result_low for exactly one cycle with done high; the receiver cannot
// stall it, so capture it on that cycle. After reset or any key write the first
// block first expands the key into the round-key memory, one word per cycle. A
// block then reads each 128-bit round key as four single-word reads from the one
// memory read port plus the registered read data: one round per key, 11 keys.
// The memory read port sets the rate.
// Write the key through cfg_valid/cfg_ready/cfg_index/cfg_data only while idle; a key
// write in the same cycle as a start transfer applies to that block.
module aes128_block_cipher_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [63:0] block_high,
	input  wire logic [63:0] block_low,
	output logic             done,
	output logic      [63:0] result_high,
	output logic      [63:0] result_low,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXP  = 4'b0010,
		ST_RND  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                       st_q;
	logic [63:0]                  key_hi_q, key_lo_q;
	logic                         kvalid_q;
	logic                         dec_q;
	logic [127:0]                 din_q;
	logic [aes_pkg::KIDX_W-1:0]   cnt_q;      // expansion word index
	logic [31:0]                  w1_q, w2_q, w3_q, w4_q; // last four words
	logic [7:0]                   rc_q;
	logic [aes_pkg::ROUND_W-1:0]  rnd_q;      // rounds applied so far
	logic [1:0]                   wsel_q;     // word within round key
	logic                         rdv_q;      // read data valid
	logic [95:0]                  kbuf_q;     // collected key words
	logic                         we;
	logic [aes_pkg::KIDX_W-1:0]   waddr, raddr;
	logic [31:0]                  wdata, rdata, tw;
	logic [127:0]                 state;
	logic [aes_pkg::ROUND_W-1:0]  kround;
	logic                         step;
	aes_pkg::rnd_ctl_t            ctl;

	assign busy      = (st_q != ST_IDLE);
	assign cfg_ready = (st_q == ST_IDLE);
	assign done      = (st_q == ST_DONE);
	assign result_high = state[127:64];
	assign result_low  = state[63:0];

	// Key expansion word: first four come from the key registers.
	always_comb begin
		tw = w4_q;
		if (cnt_q[1:0] == 2'd0) begin
			tw = aes_pkg::sub_word({w4_q[23:0], w4_q[31:24]}) ^ {rc_q, 24'd0};
		end
		case (cnt_q)
			6'd0:    wdata = key_hi_q[63:32];
			6'd1:    wdata = key_hi_q[31:0];
			6'd2:    wdata = key_lo_q[63:32];
			6'd3:    wdata = key_lo_q[31:0];
			default: wdata = w1_q ^ tw;
		endcase
	end
	assign we    = (st_q == ST_EXP);
	assign waddr = cnt_q;

	// Round key index in use: decrypt walks the schedule backwards.
	assign kround = dec_q ? aes_pkg::ROUND_W'(aes_pkg::NUM_ROUNDS) - rnd_q : rnd_q;
	assign raddr  = aes_pkg::KIDX_W'({kround, 2'b00}) + aes_pkg::KIDX_W'(wsel_q);

	aes_key_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Advance the state once the fourth word of a round key arrives.
	assign step      = (st_q == ST_RND) && rdv_q && (wsel_q == 2'd0);
	assign ctl.first = (rnd_q == '0);
	assign ctl.last  = (rnd_q == aes_pkg::ROUND_W'(aes_pkg::NUM_ROUNDS));
	assign ctl.dec   = dec_q;

	aes_round u_round (
		.clk     (clk),
		.ctl     (ctl),
		.step    (step),
		.din     (din_q),
		.rkey    ({kbuf_q, rdata}),
		.state_q (state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			kvalid_q <= 1'b0;
			key_hi_q <= '0;
			key_lo_q <= '0;
			cnt_q    <= '0;
			rnd_q    <= '0;
			wsel_q   <= '0;
			rdv_q    <= 1'b0;
			rc_q     <= 8'h01;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						kvalid_q <= 1'b0;
						case (cfg_index)
							aes_pkg::CFG_KEY_HIGH: key_hi_q <= cfg_data;
							aes_pkg::CFG_KEY_LOW:  key_lo_q <= cfg_data;
							default: ;
						endcase
					end
					if (start) begin
						cnt_q  <= '0;
						rc_q   <= 8'h01;
						rnd_q  <= '0;
						wsel_q <= '0;
						rdv_q  <= 1'b0;
						st_q   <= (kvalid_q && !cfg_valid) ? ST_RND : ST_EXP;
					end
				end
				ST_EXP: begin
					if (cnt_q[1:0] == 2'd0 && cnt_q != '0) begin
						rc_q <= aes_pkg::xt(rc_q);
					end
					if (cnt_q == aes_pkg::KIDX_W'(aes_pkg::KEY_WORDS - 1)) begin
						kvalid_q <= 1'b1;
						st_q     <= ST_RND;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_RND: begin
					// Issue reads word by word; the read data is registered and returns in the next cycle.
					rdv_q  <= 1'b1;
					wsel_q <= wsel_q + 1'b1;
					if (step) begin
						rdv_q <= 1'b0;
						wsel_q <= '0;
						if (ctl.last) begin
							st_q <= ST_DONE;
						end else begin
							rnd_q <= rnd_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			dec_q <= func;
			din_q <= {block_high, block_low};
		end
		if (st_q == ST_EXP) begin
			w1_q <= w2_q; w2_q <= w3_q; w3_q <= w4_q; w4_q <= wdata;
		end
		if (rdv_q) begin
			kbuf_q <= {kbuf_q[63:0], rdata};
		end
	end
endmodule
`default_nettype wire

FILE: sv/aes_key_mem.sv
// AES round-key store: 44 words of 32 bits, one write and one registered read.
// Depends on aes_pkg for the depth.
`default_nettype none
module aes_key_mem (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [aes_pkg::KIDX_W-1:0] waddr,
	input  wire logic [31:0]               wdata,
	input  wire logic [aes_pkg::KIDX_W-1:0] raddr,
	output logic      [31:0]               rdata
);
	logic [31:0] mem [aes_pkg::KEY_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/aes_round.sv
// AES shared round datapath: one round or key addition per step-high cycle on state_q.
// Depends on aes_pkg for S-boxes, mix functions and rnd_ctl_t.
`default_nettype none
module aes_round (
	input  wire logic              clk,
	input  wire aes_pkg::rnd_ctl_t ctl,
	input  wire logic              step,
	input  wire logic [127:0]      din,
	input  wire logic [127:0]      rkey,
	output logic      [127:0]      state_q
);
	logic [7:0]   b  [16];
	logic [7:0]   sb [16];
	logic [127:0] ss, mx, nx;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			b[i] = state_q[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (ctl.dec) begin
					sb[4*c+r] = aes_pkg::SBOX_INV[b[4 * ((c - r + 4) % 4) + r]];
				end else begin
					sb[4*c+r] = aes_pkg::SBOX[b[4 * ((c + r) % 4) + r]];
				end
			end
		end
		for (int i = 0; i < 16; i++) begin
			ss[127-8*i -: 8] = sb[i];
		end
		for (int c = 0; c < 4; c++) begin
			if (ctl.dec) begin
				mx[127-32*c -: 32] = aes_pkg::inv_mix_col(ss[127-32*c -: 32] ^ rkey[127-32*c -: 32]);
			end else begin
				mx[127-32*c -: 32] = aes_pkg::mix_col(ss[127-32*c -: 32]) ^ rkey[127-32*c -: 32];
			end
		end
		if (ctl.first) begin
			nx = din ^ rkey;
		end else if (ctl.last) begin
			nx = ss ^ rkey;
		end else begin
			nx = mx;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			state_q <= nx;
		end
	end
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the AES-128 block cipher unit: directed known vectors, then
// random blocks under changing keys, checked against known results or an in-bench model.
// Depends on aes_pkg (key register codes) and aes128_block_cipher_unit.
`timescale 1ns / 100ps
module tb;
	localparam bit FN_ENC = 1'b0;
	localparam bit FN_DEC = 1'b1;
	localparam int ROUNDS = 10;
	localparam int RK_WORDS = 4 * (ROUNDS + 1);
	localparam int RANDOM_ITEMS = 1880;
	localparam int CYCLE_LIMIT = 2000000;
	// Drain wait before a key write or at the end: one block plus a key expansion.
	localparam int SETTLE_CYCLES = 120;

	logic clk, arst_n;
	logic start, busy, func, done, cfg_valid, cfg_ready;
	logic [63:0] block_high, block_low, result_high, result_low, cfg_data;
	logic [0:0] cfg_index;

	aes128_block_cipher_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.block_high(block_high), .block_low(block_low), .done(done),
		.result_high(result_high), .result_low(result_low),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} block_t;

	// One directed row: optional key writes ahead of it, then one block.
	typedef struct {
		bit          wr_hi;
		logic [63:0] key_hi;
		bit          wr_lo;
		logic [63:0] key_lo;
		bit          dec;
		logic [63:0] in_hi;
		logic [63:0] in_lo;
		bit          known;
		logic [63:0] out_hi;
		logic [63:0] out_lo;
	} vec_t;

	logic [7:0]  fwd_sbox [256];
	logic [7:0]  rev_sbox [256];
	logic [31:0] round_keys [RK_WORDS];
	logic [63:0] cur_key_hi, cur_key_lo;
	block_t      cipher_out_q [$];
	int          mismatches, blocks_sent, results_seen, key_writes;
	int          cycles;

	function automatic logic [7:0] gf_dbl(logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[0])
				p ^= a;
			a = gf_dbl(a);
			b = b >> 1;
		end
		return p;
	endfunction

	// Build both substitution boxes from the field inverse and the affine map.
	function automatic void build_sboxes();
		logic [7:0] r;
		for (int x = 0; x < 256; x++) begin
			r = 8'h01;
			for (int k = 0; k < 254; k++)
				r = gf_mul(r, x[7:0]);
			if (x == 0)
				r = 8'h00;
			r = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
				^ {r[3:0], r[7:4]} ^ 8'h63;
			fwd_sbox[x] = r;
			rev_sbox[r] = x[7:0];
		end
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] t;
		logic [7:0] rcon;
		rcon = 8'h01;
		round_keys[0] = cur_key_hi[63:32];
		round_keys[1] = cur_key_hi[31:0];
		round_keys[2] = cur_key_lo[63:32];
		round_keys[3] = cur_key_lo[31:0];
		for (int i = 4; i < RK_WORDS; i++) begin
			t = round_keys[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_sbox[t[31:24]], fwd_sbox[t[23:16]], fwd_sbox[t[15:8]],
					fwd_sbox[t[7:0]]} ^ {rcon, 24'h0};
				rcon = gf_dbl(rcon);
			end
			round_keys[i] = round_keys[i-4] ^ t;
		end
	endfunction

	// State byte i sits at bits 127-8i; byte 4c+r is row r of column c.
	function automatic logic [127:0] add_round_key(logic [127:0] st, int rnd);
		for (int c = 0; c < 4; c++)
			st[127-32*c -: 32] ^= round_keys[4*rnd+c];
		return st;
	endfunction

	function automatic logic [127:0] sub_and_shift(logic [127:0] st, bit inv);
		logic [127:0] src;
		logic [7:0] b;
		int from;
		src = st;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				from = inv ? 4 * ((c - r + 4) % 4) + r : 4 * ((c + r) % 4) + r;
				b = src[127-8*from -: 8];
				st[127-8*(4*c+r) -: 8] = inv ? rev_sbox[b] : fwd_sbox[b];
			end
		return st;
	endfunction

	function automatic logic [127:0] mix_columns(logic [127:0] st, bit inv);
		logic [7:0] coef [4];
		logic [7:0] col [4];
		logic [7:0] v;
		if (inv)
			coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else
			coef = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++)
				col[k] = st[127-8*(4*c+k) -: 8];
			for (int r = 0; r < 4; r++) begin
				v = 8'h00;
				for (int k = 0; k < 4; k++)
					v ^= gf_mul(coef[(k - r + 4) % 4], col[k]);
				st[127-8*(4*c+r) -: 8] = v;
			end
		end
		return st;
	endfunction

	function automatic block_t aes_transform(bit dec, logic [63:0] hi, logic [63:0] lo);
		logic [127:0] st;
		block_t res;
		st = {hi, lo};
		if (!dec) begin
			st = add_round_key(st, 0);
			for (int rnd = 1; rnd < ROUNDS; rnd++)
				st = add_round_key(mix_columns(sub_and_shift(st, 1'b0), 1'b0), rnd);
			st = add_round_key(sub_and_shift(st, 1'b0), ROUNDS);
		end else begin
			st = add_round_key(st, ROUNDS);
			for (int rnd = ROUNDS - 1; rnd > 0; rnd--)
				st = mix_columns(add_round_key(sub_and_shift(st, 1'b1), rnd), 1'b1);
			st = add_round_key(sub_and_shift(st, 1'b1), 0);
		end
		res.hi = st[127:64];
		res.lo = st[63:0];
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Wait until every expected result is back, then let the unit settle to idle.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (cipher_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(logic [0:0] idx, logic [63:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == aes_pkg::CFG_KEY_HIGH)
			cur_key_hi = value;
		else
			cur_key_lo = value;
		expand_round_keys();
		key_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = {$urandom, $urandom};
	endtask

	// Present one block and hold it until the unit takes it; start stays high
	// afterwards until the next gap, drain or block replaces it at a falling edge.
	task automatic send_block(bit dec, logic [63:0] hi, logic [63:0] lo, bit known,
		logic [63:0] out_hi, logic [63:0] out_lo);
		block_t want;
		@(negedge clk);
		start = 1'b1;
		func = dec;
		block_high = hi;
		block_low = lo;
		do @(posedge clk); while (busy);
		if (known) begin
			want.hi = out_hi;
			want.lo = out_lo;
		end else
			want = aes_transform(dec, hi, lo);
		cipher_out_q = {cipher_out_q, want};
		blocks_sent++;
	endtask

	// Mostly back to back, sometimes short gaps, rarely long ones.
	task automatic sender_gap();
		int pick, len;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return;
		len = (pick < 92) ? $urandom_range(1, 4) : $urandom_range(20, 80);
		@(negedge clk);
		start = 1'b0;
		func = 1'($urandom);
		block_high = {$urandom, $urandom};
		block_low = {$urandom, $urandom};
		repeat (len) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 64'h0;
			1: return '1;
			2: return 64'h1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Check each transfer against the oldest expectation.
	always @(posedge clk) begin
		block_t want;
		if (arst_n && done) begin
			results_seen++;
			if (cipher_out_q.size() == 0) begin
				$display("%0t: unexpected result %h_%h", $time, result_high, result_low);
				mismatches++;
			end else begin
				want = cipher_out_q.pop_front();
				if (result_high !== want.hi) begin
					$display("%0t: result_high expected %h actual %h", $time, want.hi,
						result_high);
					mismatches++;
				end
				if (result_low !== want.lo) begin
					$display("%0t: result_low expected %h actual %h", $time, want.lo,
						result_low);
					mismatches++;
				end
			end
		end
	end

	// Hard stop for a hung unit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, cipher_out_q.size());
			$display("status: fail");
			$finish;
		end
	end

	vec_t directed [16] = '{
		// Reset key (all zero), no key write yet: known vectors, then extremes.
		'{0, 0, 0, 0, FN_ENC, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
		'{0, 0, 0, 0, FN_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0},
		'{0, 0, 0, 0, FN_ENC, '1, '1, 0, 0, 0},
		'{0, 0, 0, 0, FN_DEC, 64'h0, 64'h0, 0, 0, 0},
		'{0, 0, 0, 0, FN_DEC, '1, '1, 0, 0, 0},
		'{0, 0, 0, 0, FN_ENC, 64'h8000000000000000, 64'h1, 0, 0, 0},
		// Standard example key and block.
		'{1, 64'h0001020304050607, 1, 64'h08090a0b0c0d0e0f, FN_ENC,
			64'h0011223344556677, 64'h8899aabbccddeeff, 1,
			64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
		'{0, 0, 0, 0, FN_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
			64'h0011223344556677, 64'h8899aabbccddeeff},
		'{0, 0, 0, 0, FN_ENC, 64'h0, 64'h0, 0, 0, 0},
		// All-ones key.
		'{1, '1, 1, '1, FN_ENC, 64'h0, 64'h0, 0, 0, 0},
		'{0, 0, 0, 0, FN_ENC, '1, '1, 0, 0, 0},
		'{0, 0, 0, 0, FN_DEC, '1, 64'h0, 0, 0, 0},
		// Change only one half of the key between blocks.
		'{0, 0, 1, 64'h0, FN_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0, 0},
		'{0, 0, 0, 0, FN_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0, 0},
		'{1, 64'h0, 0, 0, FN_ENC, '1, 64'h0, 0, 0, 0},
		'{0, 0, 0, 0, FN_DEC, 64'h0, '1, 0, 0, 0}
	};

	initial begin
		block_t ct;
		bit dec;
		logic [63:0] hi, lo;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_ENC;
		block_high = '0;
		block_low = '0;
		cfg_valid = 1'b0;
		cfg_index = aes_pkg::CFG_KEY_HIGH;
		cfg_data = '0;
		cur_key_hi = '0;
		cur_key_lo = '0;
		build_sboxes();
		expand_round_keys();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: key writes happen only with the unit drained.
		foreach (directed[i]) begin
			if (directed[i].wr_hi || directed[i].wr_lo)
				drain();
			if (directed[i].wr_hi)
				write_key(aes_pkg::CFG_KEY_HIGH, directed[i].key_hi);
			if (directed[i].wr_lo)
				write_key(aes_pkg::CFG_KEY_LOW, directed[i].key_lo);
			send_block(directed[i].dec, directed[i].in_hi, directed[i].in_lo,
				directed[i].known, directed[i].out_hi, directed[i].out_lo);
			if (i % 3 == 0)
				sender_gap();
		end

		// Random blocks under a new key every so often; extremes appear among the keys.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: write_key(aes_pkg::CFG_KEY_HIGH, pick_word());
					1: write_key(aes_pkg::CFG_KEY_LOW, pick_word());
					default: begin
						write_key(aes_pkg::CFG_KEY_HIGH, pick_word());
						write_key(aes_pkg::CFG_KEY_LOW, pick_word());
					end
				endcase
			end
			// Hold off until the pipe is empty once in a while.
			if (n % 400 == 200)
				drain();
			dec = 1'($urandom);
			hi = pick_word();
			lo = pick_word();
			// Sometimes feed a ciphertext back for decryption.
			if ($urandom_range(0, 7) == 0) begin
				ct = aes_transform(FN_ENC, hi, lo);
				hi = ct.hi;
				lo = ct.lo;
				dec = FN_DEC;
			end
			send_block(dec, hi, lo, 0, 0, 0);
			// Long stretches with no idling at all.
			if ((n / 100) % 3 != 2)
				sender_gap();
		end

		drain();
		$display("covered %0d blocks in both directions, %0d key writes, %0d results",
			blocks_sent, key_writes, results_seen);
		if (mismatches == 0 && cipher_out_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
